### sv/art_pkg.sv
// Shared types and constants for the advertiser rate tracker.
// Used by art_entry_mem and advertiser_rate_tracker_unit.
package art_pkg;

    typedef struct packed {
        logic [47:0] addr;
        logic [31:0] window_start;
        logic [31:0] last_seen;
        logic [15:0] count;
        logic [7:0]  dbm;
    } entry_t;

    localparam logic [1:0] ST_COUNTED = 2'd0;
    localparam logic [1:0] ST_RESTART = 2'd1;
    localparam logic [1:0] ST_DROPPED = 2'd2;
    localparam logic [1:0] ST_PRUNED  = 2'd3;

    localparam logic MODE_OBSERVE = 1'b0;
    localparam logic MODE_PRUNE   = 1'b1;

    localparam logic [1:0] CFG_RATE_WINDOW = 2'd0;
    localparam logic [1:0] CFG_THRESHOLD   = 2'd1;
    localparam logic [1:0] CFG_AGE_LIMIT   = 2'd2;

    localparam logic [15:0] RATE_WINDOW_RST = 16'd1000;
    localparam logic [15:0] THRESHOLD_RST   = 16'd20;
    localparam logic [31:0] AGE_LIMIT_RST   = 32'd30000;

    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

endpackage

### sv/advertiser_rate_tracker_unit.sv
// Advertiser rate tracker: a table of sender addresses with per-sender windowed packet counts.
// Each transaction walks the whole table, one entry read per cycle from its memory; an observe
// transaction then decides and writes in S_DECIDE, while a prune finishes at the end of the walk.
// The next start is taken in the cycle of the done strobe.
// Reset clears all valid bits, the entry count and the registers to their defaults at once.
// Each result is shown for one cycle under done; the receiver cannot stall it.
module advertiser_rate_tracker_unit #(
    parameter int TABLE_ENTRIES = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               mode,
    input  logic [47:0]        sender_addr,
    input  logic signed [7:0]  signal_dbm,
    input  logic               already_known,
    input  logic [31:0]        now_ms,
    output logic               done,
    output logic [1:0]         status,
    output logic               high_rate,
    output logic [15:0]        packet_count,
    output logic signed [7:0]  flag_dbm,
    output logic [5:0]         occupancy,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_wdata
);
    import art_pkg::*;

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam logic [CNT_W-1:0] SCAN_END = CNT_W'(TABLE_ENTRIES);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE
    } state_t;

    state_t state_reg;

    logic [15:0] rate_window_reg;
    logic [15:0] threshold_reg;
    logic [31:0] age_limit_reg;

    logic [TABLE_ENTRIES-1:0] valid_reg;
    logic [CNT_W-1:0]         total_reg;

    logic        mode_reg;
    logic [47:0] addr_reg;
    logic [7:0]  dbm_reg;
    logic        known_reg;
    logic [31:0] now_reg;

    logic [CNT_W-1:0] idx_reg;
    logic             cmp_vld_reg;
    logic [IDX_W-1:0] cmp_idx_reg;

    logic             hit_found_reg;
    logic [IDX_W-1:0] hit_idx_reg;
    logic [31:0]      hit_ws_reg;
    logic [15:0]      hit_cnt_reg;
    logic             free_found_reg;
    logic [IDX_W-1:0] free_idx_reg;

    logic        done_reg;
    logic [1:0]  status_reg;
    logic        high_rate_reg;
    logic [15:0] count_reg;
    logic [7:0]  flag_dbm_reg;
    logic [5:0]  occupancy_reg;

    logic [IDX_W-1:0] scan_idx;
    logic             issuing;
    entry_t           rd_entry;
    entry_t           wr_entry;
    logic             mem_we;
    logic [IDX_W-1:0] wr_idx;

    logic [31:0] cmp_stamp;
    logic [31:0] cmp_limit;
    logic        cmp_expired;

    logic        cmp_valid_entry;
    logic        scan_hit;
    logic        prune_drop;
    logic        drop;
    logic        restart;
    logic [31:0] base_ws;
    logic [15:0] base_cnt;
    logic [15:0] cnt_inc;
    logic [15:0] new_cnt;
    logic        flag;
    logic [CNT_W-1:0] total_after;
    logic [CNT_W+5:0] occ_wide;

    assign scan_idx = idx_reg[IDX_W-1:0];
    assign issuing  = (state_reg == S_SCAN) && (idx_reg != SCAN_END);

    art_entry_mem #(
        .DEPTH (TABLE_ENTRIES),
        .IDX_W (IDX_W)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (wr_idx),
        .wdata (wr_entry),
        .raddr (scan_idx),
        .rdata (rd_entry)
    );

    // The one time comparator serves the age check of a prune walk and the window check
    // of an observation.
    always_comb
    begin
        base_ws  = hit_found_reg ? hit_ws_reg : now_reg;
        base_cnt = hit_found_reg ? hit_cnt_reg : 16'd0;
        if (state_reg == S_SCAN)
        begin
            cmp_stamp = rd_entry.last_seen;
            cmp_limit = age_limit_reg;
        end
        else
        begin
            cmp_stamp = base_ws;
            cmp_limit = {16'd0, rate_window_reg};
        end
    end

    art_time_cmp u_cmp (
        .now     (now_reg),
        .stamp   (cmp_stamp),
        .limit   (cmp_limit),
        .expired (cmp_expired)
    );

    always_comb
    begin
        cmp_valid_entry = cmp_vld_reg && valid_reg[cmp_idx_reg];
        scan_hit   = cmp_valid_entry && (mode_reg == MODE_OBSERVE) && !hit_found_reg
                     && (rd_entry.addr == addr_reg);
        prune_drop = cmp_valid_entry && (mode_reg == MODE_PRUNE) && cmp_expired;

        drop    = !hit_found_reg && !free_found_reg;
        restart = cmp_expired;
        cnt_inc = (base_cnt != COUNT_MAX) ? base_cnt + 16'd1 : base_cnt;
        new_cnt = restart ? 16'd1 : cnt_inc;
        flag    = !restart && !known_reg && (cnt_inc >= threshold_reg);
        wr_idx  = hit_found_reg ? hit_idx_reg : free_idx_reg;

        wr_entry.addr         = addr_reg;
        wr_entry.window_start = restart ? now_reg : base_ws;
        wr_entry.last_seen    = now_reg;
        wr_entry.count        = new_cnt;
        wr_entry.dbm          = dbm_reg;

        mem_we = (state_reg == S_DECIDE) && !drop;

        if ((state_reg == S_DECIDE) && !drop && !hit_found_reg)
        begin
            total_after = total_reg + CNT_W'(1);
        end
        else
        begin
            total_after = total_reg;
        end
        occ_wide = {6'd0, total_after};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            rate_window_reg <= RATE_WINDOW_RST;
            threshold_reg   <= THRESHOLD_RST;
            age_limit_reg   <= AGE_LIMIT_RST;
            valid_reg       <= '0;
            total_reg       <= '0;
            mode_reg        <= MODE_OBSERVE;
            addr_reg        <= '0;
            dbm_reg         <= '0;
            known_reg       <= 1'b0;
            now_reg         <= '0;
            idx_reg         <= '0;
            cmp_vld_reg     <= 1'b0;
            cmp_idx_reg     <= '0;
            hit_found_reg   <= 1'b0;
            hit_idx_reg     <= '0;
            hit_ws_reg      <= '0;
            hit_cnt_reg     <= '0;
            free_found_reg  <= 1'b0;
            free_idx_reg    <= '0;
            done_reg        <= 1'b0;
            status_reg      <= ST_COUNTED;
            high_rate_reg   <= 1'b0;
            count_reg       <= '0;
            flag_dbm_reg    <= '0;
            occupancy_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;

            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_RATE_WINDOW: rate_window_reg <= cfg_wdata[15:0];
                    CFG_THRESHOLD:   threshold_reg   <= cfg_wdata[15:0];
                    CFG_AGE_LIMIT:   age_limit_reg   <= cfg_wdata;
                    default:         ;
                endcase
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        mode_reg       <= mode;
                        addr_reg       <= sender_addr;
                        dbm_reg        <= signal_dbm;
                        known_reg      <= already_known;
                        now_reg        <= now_ms;
                        idx_reg        <= '0;
                        cmp_vld_reg    <= 1'b0;
                        hit_found_reg  <= 1'b0;
                        free_found_reg <= 1'b0;
                        state_reg      <= S_SCAN;
                    end
                end

                S_SCAN:
                begin
                    // Issue stage: the valid bits are flip-flops, so the free search
                    // runs alongside the memory read.
                    cmp_vld_reg <= issuing;
                    cmp_idx_reg <= scan_idx;
                    if (issuing)
                    begin
                        idx_reg <= idx_reg + CNT_W'(1);
                        if (!valid_reg[scan_idx] && !free_found_reg)
                        begin
                            free_found_reg <= 1'b1;
                            free_idx_reg   <= scan_idx;
                        end
                    end

                    // Compare stage: the entry read in the previous cycle.
                    if (scan_hit)
                    begin
                        hit_found_reg <= 1'b1;
                        hit_idx_reg   <= cmp_idx_reg;
                        hit_ws_reg    <= rd_entry.window_start;
                        hit_cnt_reg   <= rd_entry.count;
                    end
                    if (prune_drop)
                    begin
                        valid_reg[cmp_idx_reg] <= 1'b0;
                        total_reg              <= total_reg - CNT_W'(1);
                    end

                    if (!issuing && !cmp_vld_reg)
                    begin
                        if (mode_reg == MODE_PRUNE)
                        begin
                            done_reg      <= 1'b1;
                            status_reg    <= ST_PRUNED;
                            high_rate_reg <= 1'b0;
                            count_reg     <= '0;
                            flag_dbm_reg  <= '0;
                            occupancy_reg <= occ_wide[5:0];
                            state_reg     <= S_IDLE;
                        end
                        else
                        begin
                            state_reg <= S_DECIDE;
                        end
                    end
                end

                S_DECIDE:
                begin
                    done_reg      <= 1'b1;
                    occupancy_reg <= occ_wide[5:0];
                    total_reg     <= total_after;
                    state_reg     <= S_IDLE;
                    if (drop)
                    begin
                        status_reg    <= ST_DROPPED;
                        high_rate_reg <= 1'b0;
                        count_reg     <= '0;
                        flag_dbm_reg  <= '0;
                    end
                    else
                    begin
                        if (!hit_found_reg)
                        begin
                            valid_reg[free_idx_reg] <= 1'b1;
                        end
                        status_reg    <= restart ? ST_RESTART : ST_COUNTED;
                        high_rate_reg <= flag;
                        count_reg     <= new_cnt;
                        flag_dbm_reg  <= flag ? dbm_reg : 8'd0;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy         = (state_reg != S_IDLE);
    assign done         = done_reg;
    assign status       = status_reg;
    assign high_rate    = high_rate_reg;
    assign packet_count = count_reg;
    assign flag_dbm     = flag_dbm_reg;
    assign occupancy    = occupancy_reg;

endmodule

### sv/art_entry_mem.sv
// Entry table of the advertiser rate tracker: one write port, one registered read port.
// Depends on art_pkg for the entry layout.
module art_entry_mem #(
    parameter int DEPTH = 32,
    parameter int IDX_W = 5
) (
    input  logic              clk,
    input  logic              we,
    input  logic [IDX_W-1:0]  waddr,
    input  art_pkg::entry_t   wdata,
    input  logic [IDX_W-1:0]  raddr,
    output art_pkg::entry_t   rdata
);
    import art_pkg::*;

    entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

### sv/art_time_cmp.sv
// Shared elapsed-time check: wrapping difference now - stamp compared against a limit.
// Depends on nothing beyond its ports.
module art_time_cmp (
    input  logic [31:0] now,
    input  logic [31:0] stamp,
    input  logic [31:0] limit,
    output logic        expired
);
    logic [31:0] elapsed;

    // The subtraction wraps modulo 2^32, as the time base does.
    assign elapsed = now - stamp;
    assign expired = elapsed > limit;

endmodule

### bench/advertiser_rate_tracker_unit_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for advertiser_rate_tracker_unit: a scoreboard predicts every result.
// Depends on art_pkg and the unit; runs directed cases, then random phases of settings.
import art_pkg::*;

localparam int TRACK_ENTRIES = 32;
localparam int POOL_SIZE     = 48;

typedef struct packed {
    logic [1:0]  status;
    logic        high_rate;
    logic [15:0] count;
    logic [7:0]  dbm;
    logic [5:0]  occupancy;
} tracker_result_t;

class rate_scoreboard;
    logic [47:0] addr_tab  [TRACK_ENTRIES];
    logic [31:0] start_tab [TRACK_ENTRIES];
    logic [31:0] seen_tab  [TRACK_ENTRIES];
    logic [15:0] count_tab [TRACK_ENTRIES];
    logic        valid_tab [TRACK_ENTRIES];
    int          live_count;
    logic [15:0] win_len;
    logic [15:0] threshold;
    logic [31:0] age_ms;
    tracker_result_t expected_q[$];
    int          mismatches;

    function new();
        foreach (valid_tab[i])
            valid_tab[i] = 1'b0;
        live_count = 0;
        win_len    = RATE_WINDOW_RST;
        threshold  = THRESHOLD_RST;
        age_ms     = AGE_LIMIT_RST;
        mismatches = 0;
    endfunction

    function void set_register(logic [1:0] idx, logic [31:0] val);
        case (idx)
            CFG_RATE_WINDOW: win_len   = val[15:0];
            CFG_THRESHOLD:   threshold = val[15:0];
            CFG_AGE_LIMIT:   age_ms    = val;
            default: ;
        endcase
    endfunction

    function int pending();
        return expected_q.size();
    endfunction

    // Works out the single result of one accepted transaction and updates the table.
    function void note_transaction(logic m, logic [47:0] a, logic [7:0] d, logic k,
                                   logic [31:0] t);
        int hit;
        int free_idx;
        logic [31:0] elapsed;
        tracker_result_t res;
        res = '0;
        hit = -1;
        free_idx = -1;
        if (m == MODE_PRUNE) begin
            for (int i = 0; i < TRACK_ENTRIES; i++) begin
                elapsed = t - seen_tab[i];
                if (valid_tab[i] && elapsed > age_ms) begin
                    valid_tab[i] = 1'b0;
                    live_count--;
                end
            end
            res.status = ST_PRUNED;
        end else begin
            for (int i = 0; i < TRACK_ENTRIES; i++) begin
                if (valid_tab[i]) begin
                    if (hit < 0 && addr_tab[i] == a)
                        hit = i;
                end else if (free_idx < 0) begin
                    free_idx = i;
                end
            end
            if (hit < 0 && free_idx < 0) begin
                res.status = ST_DROPPED;
            end else begin
                if (hit < 0) begin
                    hit = free_idx;
                    valid_tab[hit] = 1'b1;
                    live_count++;
                    addr_tab[hit]  = a;
                    start_tab[hit] = t;
                    count_tab[hit] = '0;
                end
                seen_tab[hit] = t;
                elapsed = t - start_tab[hit];
                if (elapsed > {16'd0, win_len}) begin
                    start_tab[hit] = t;
                    count_tab[hit] = 16'd1;
                    res.status = ST_RESTART;
                    res.count  = 16'd1;
                end else begin
                    if (count_tab[hit] != COUNT_MAX)
                        count_tab[hit]++;
                    res.status = ST_COUNTED;
                    res.count  = count_tab[hit];
                    if (!k && count_tab[hit] >= threshold) begin
                        res.high_rate = 1'b1;
                        res.dbm       = d;
                    end
                end
            end
        end
        res.occupancy = live_count[5:0];
        expected_q.push_back(res);
    endfunction

    task report_mismatch(string msg);
        $display("%0t: mismatch: %s", $time, msg);
        mismatches++;
    endtask

    task compare_field(string name, logic [15:0] got, logic [15:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
    endtask

    task check_result(tracker_result_t got);
        tracker_result_t want;
        if (expected_q.size() == 0) begin
            report_mismatch("result strobe with no transaction outstanding");
        end else begin
            want = expected_q.pop_front();
            compare_field("status", 16'(got.status), 16'(want.status));
            compare_field("high_rate", 16'(got.high_rate), 16'(want.high_rate));
            compare_field("packet_count", got.count, want.count);
            compare_field("flag_dbm", 16'(got.dbm), 16'(want.dbm));
            compare_field("occupancy", 16'(got.occupancy), 16'(want.occupancy));
        end
    endtask
endclass

module advertiser_rate_tracker_unit_tb;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic               mode;
    logic [47:0]        sender_addr;
    logic signed [7:0]  signal_dbm;
    logic               already_known;
    logic [31:0]        now_ms;
    logic               done;
    logic [1:0]         status;
    logic               high_rate;
    logic [15:0]        packet_count;
    logic signed [7:0]  flag_dbm;
    logic [5:0]         occupancy;
    logic               cfg_we;
    logic [1:0]         cfg_index;
    logic [31:0]        cfg_wdata;

    rate_scoreboard sb;
    logic [47:0]    addr_pool [POOL_SIZE];
    logic [31:0]    clock_ms;

    logic [15:0] phase_window [6] = '{16'd1000, 16'd0, 16'd65535, 16'd200, 16'd50, 16'd3000};
    logic [15:0] phase_thresh [6] = '{16'd20, 16'd1, 16'd65535, 16'd4, 16'd0, 16'd8};
    logic [31:0] phase_age    [6] = '{32'd30000, 32'd0, 32'hFFFF_FFFF, 32'd5000, 32'd300,
                                      32'd20000};

    advertiser_rate_tracker_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .mode          (mode),
        .sender_addr   (sender_addr),
        .signal_dbm    (signal_dbm),
        .already_known (already_known),
        .now_ms        (now_ms),
        .done          (done),
        .status        (status),
        .high_rate     (high_rate),
        .packet_count  (packet_count),
        .flag_dbm      (flag_dbm),
        .occupancy     (occupancy),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

    always @(posedge clk)
    begin
        if (done === 1'b1)
            sb.check_result('{status, high_rate, packet_count, flag_dbm, occupancy});
    end

    // Presents one transaction and returns at the edge that accepts it, with start still high.
    task automatic send_item(input logic m, input logic [47:0] a, input logic [7:0] d,
                             input logic k, input logic [31:0] t);
        mode          <= m;
        sender_addr   <= a;
        signal_dbm    <= d;
        already_known <= k;
        now_ms        <= t;
        start         <= 1'b1;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        sb.note_transaction(m, a, d, k, t);
    endtask

    task automatic drain();
        start <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0 || busy !== 1'b0);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        sb.set_register(idx, val);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        logic [31:0] base;
        logic [63:0] wide;
        logic [47:0] a;
        logic [31:0] jump;
        logic        m;
        int unsigned pick;
        int unsigned burst_left;

        sb = new();
        rst_n         <= 1'b0;
        start         <= 1'b0;
        mode          <= MODE_OBSERVE;
        sender_addr   <= '0;
        signal_dbm    <= '0;
        already_known <= 1'b0;
        now_ms        <= '0;
        cfg_we        <= 1'b0;
        cfg_index     <= CFG_RATE_WINDOW;
        cfg_wdata     <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Odd pool entries differ from their neighbor in one address bit only.
        for (int i = 0; i < POOL_SIZE; i++) begin
            wide = {$urandom(), $urandom()};
            if (i % 2 == 1)
                addr_pool[i] = addr_pool[i-1] ^ (48'd1 << $urandom_range(0, 47));
            else
                addr_pool[i] = wide[47:0];
        end

        // Reset settings: empty prune, window edge exactly at the limit, restart across
        // the time wrap, age edge exactly at the limit, then a prune that empties the table.
        base = 32'hFFFF_FE00;
        send_item(MODE_PRUNE, 48'd0, 8'h00, 1'b0, base);
        send_item(MODE_OBSERVE, 48'd0, 8'h80, 1'b0, base);
        send_item(MODE_OBSERVE, 48'd0, 8'h7F, 1'b0, base + 32'd1000);
        send_item(MODE_OBSERVE, 48'd0, 8'h01, 1'b0, base + 32'd2001);
        send_item(MODE_OBSERVE, 48'hFFFF_FFFF_FFFF, 8'h7F, 1'b1, base + 32'd2001);
        send_item(MODE_PRUNE, 48'hFFFF_FFFF_FFFF, 8'hFF, 1'b1, base + 32'd32001);
        send_item(MODE_PRUNE, 48'd0, 8'h00, 1'b0, base + 32'd32002);

        // Flagging at a low threshold, a known sender, and a near-miss address.
        write_reg(CFG_THRESHOLD, 32'd2);
        send_item(MODE_OBSERVE, 48'h5555_AAAA_5555, 8'hFF, 1'b0, 32'd100);
        send_item(MODE_OBSERVE, 48'h5555_AAAA_5555, 8'h55, 1'b0, 32'd100);
        send_item(MODE_OBSERVE, 48'h5555_AAAA_5555, 8'hAA, 1'b1, 32'd100);
        send_item(MODE_OBSERVE, 48'h5555_AAAA_5554, 8'h10, 1'b0, 32'd100);

        // A zero window counts only at the same millisecond and restarts otherwise.
        write_reg(CFG_RATE_WINDOW, 32'd0);
        send_item(MODE_OBSERVE, 48'h5555_AAAA_5555, 8'hC3, 1'b0, 32'd100);
        send_item(MODE_OBSERVE, 48'h5555_AAAA_5555, 8'h3C, 1'b0, 32'd101);

        clock_ms   = $urandom();
        burst_left = $urandom_range(1, 12);
        for (int p = 0; p < 6; p++) begin
            write_reg(CFG_RATE_WINDOW, {16'd0, phase_window[p]});
            write_reg(CFG_THRESHOLD, {16'd0, phase_thresh[p]});
            write_reg(CFG_AGE_LIMIT, phase_age[p]);
            for (int n = 0; n < 125; n++) begin
                pick = $urandom_range(0, 99);
                m = (pick < 8) ? MODE_PRUNE : MODE_OBSERVE;

                // Often a few busy senders, otherwise the wider pool, rarely a stranger.
                pick = $urandom_range(0, 99);
                wide = {$urandom(), $urandom()};
                if (pick < 40)
                    a = addr_pool[$urandom_range(0, 3)];
                else if (pick < 95)
                    a = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
                else
                    a = wide[47:0];

                pick = $urandom_range(0, 99);
                if (m == MODE_PRUNE && pick < 50) begin
                    jump = (phase_age[p] > 32'h4000_0000) ? 32'h4000_0000
                         : phase_age[p] + (phase_age[p] >> 2) + 32'd1;
                    clock_ms += $urandom_range(0, jump);
                end else if (pick < 75) begin
                    clock_ms += $urandom_range(0, phase_window[p] / 4 + 2);
                end else if (pick < 97) begin
                    clock_ms += $urandom_range(0, 2 * phase_window[p] + 64);
                end else begin
                    clock_ms = $urandom();
                end

                send_item(m, a, 8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0,
                          clock_ms);

                burst_left--;
                if (burst_left == 0) begin
                    start <= 1'b0;
                    repeat ($urandom_range(1, 40)) @(posedge clk);
                    burst_left = $urandom_range(1, 12);
                end
            end
        end

        drain();
        repeat (40) @(posedge clk);
        if (sb.mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

### advertiser_rate_tracker_unit.f
sv/art_pkg.sv
sv/art_entry_mem.sv
sv/art_time_cmp.sv
sv/advertiser_rate_tracker_unit.sv
bench/advertiser_rate_tracker_unit_tb.sv
